>>> rtl/siph_pkg.sv
// ----------------------------------------------------------------------------
// siph_pkg
// Shared types, constants and the tail padding function of the keyed hash core.
// ----------------------------------------------------------------------------
package siph_pkg;

	localparam logic [63:0] INIT0 = 64'h736f6d6570736575;
	localparam logic [63:0] INIT1 = 64'h646f72616e646f6d;
	localparam logic [63:0] INIT2 = 64'h6c7967656e657261;
	localparam logic [63:0] INIT3 = 64'h7465646279746573;

	localparam logic [63:0] KEY_LOW_RST  = 64'h00000000DEADBEEF;
	localparam logic [63:0] KEY_HIGH_RST = 64'h00000000F00DF17E;

	localparam logic [63:0] FIN_MARK = 64'h00000000000000FF;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_VARIANT  = 2'd2;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} lanes_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_FIN,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_ROUND,
		OP_ABSORB,
		OP_ABSORB_FIN
	} lane_op_t;

	typedef struct packed {
		logic     accept;
		logic     chain;
		lane_op_t op;
		logic     emit;
	} seq_ctrl_t;

	function automatic logic [7:0] byte_at(input logic [63:0] w, input logic [2:0] idx);
		logic [5:0] pos;
		pos = {idx, 3'b000};
		return w[pos +: 8];
	endfunction

	// Padded last word: whole low half copied for 4..7 tail bytes, remaining
	// tail bytes picked into bytes 4..6, total length in byte 7.
	function automatic logic [63:0] pad_word(input logic [63:0] w, input logic [2:0] r,
	                                         input logic [7:0] len);
		logic [63:0] p;
		logic [1:0]  m;
		logic [2:0]  q;
		p = '0;
		m = r[1:0];
		q = {r[2], 2'b00};
		if (r[2]) begin
			p[31:0] = w[31:0];
		end
		if (m != 2'd0) begin
			p[39:32] = byte_at(w, q);
			p[47:40] = byte_at(w, q + {2'b00, m[1]});
			p[55:48] = byte_at(w, q + {1'b0, m} - 3'd1);
		end
		p[63:56] = len;
		return p;
	endfunction

endpackage

>>> rtl/siph_round.sv
// ----------------------------------------------------------------------------
// siph_round
// One SipRound over the four lanes; the shared unit of the core.
// ----------------------------------------------------------------------------
module siph_round import siph_pkg::*; (
	input  lanes_t lanes_in,
	output lanes_t lanes_out
);

	logic [63:0] a1, b1, c1, d1, b2, d2, a2, c2, a3, b3, c3, d3;

	always_comb begin
		a1 = lanes_in.v0 + lanes_in.v1;
		c1 = lanes_in.v2 + lanes_in.v3;
		b1 = {lanes_in.v1[50:0], lanes_in.v1[63:51]} ^ a1;
		d1 = {lanes_in.v3[47:0], lanes_in.v3[63:48]} ^ c1;
		a2 = {a1[31:0], a1[63:32]};
		c2 = c1 + b1;
		a3 = a2 + d1;
		b2 = {b1[46:0], b1[63:47]};
		d2 = {d1[42:0], d1[63:43]};
		b3 = b2 ^ c2;
		d3 = d2 ^ a3;
		c3 = {c2[31:0], c2[63:32]};
		lanes_out.v0 = a3;
		lanes_out.v1 = b3;
		lanes_out.v2 = c3;
		lanes_out.v3 = d3;
	end

endmodule

>>> rtl/siph_seq.sv
// ----------------------------------------------------------------------------
// siph_seq
// Round sequencer: counts update and final rounds and steers the lane update.
// ----------------------------------------------------------------------------
module siph_seq import siph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      is_last,
	input  logic      variant,
	input  logic      out_free,
	output logic      in_ready,
	output seq_ctrl_t ctrl
);

	seq_state_t state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic       last_q;
	logic       upd_end;

	assign upd_end = (state_q == ST_UPD) && (cnt_q == 2'd0);

	// next state and round counter
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.accept) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (cnt_q != 2'd0) begin
					cnt_d = cnt_q - 2'd1;
				end else if (last_q) begin
					state_d = ST_FIN;
					cnt_d   = variant ? 2'd2 : 2'd3;
				end else if (!ctrl.accept) begin
					state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (cnt_q != 2'd0) begin
					cnt_d = cnt_q - 2'd1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (ctrl.accept) begin
			cnt_d = variant ? 2'd0 : 2'd1;
		end
	end

	// outputs
	always_comb begin
		in_ready    = (state_q == ST_IDLE) || (upd_end && !last_q);
		ctrl.accept = in_ready && in_valid;
		ctrl.chain  = (state_q == ST_UPD);
		ctrl.emit   = 1'b0;
		ctrl.op     = OP_HOLD;
		unique case (state_q)
			ST_IDLE: ctrl.op = OP_HOLD;
			ST_UPD: begin
				if (cnt_q != 2'd0) begin
					ctrl.op = OP_ROUND;
				end else if (last_q) begin
					ctrl.op = OP_ABSORB_FIN;
				end else begin
					ctrl.op = OP_ABSORB;
				end
			end
			ST_FIN: ctrl.op = OP_ROUND;
			ST_EMIT: ctrl.emit = out_free;
			default: ctrl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 2'd0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ctrl.accept) begin
				last_q <= is_last;
			end
		end
	end

endmodule

>>> rtl/siphash_keyed_hash_core.sv
// ----------------------------------------------------------------------------
// siphash_keyed_hash_core
// Keyed 64-bit SipHash over a message of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Usage: a message is a run of input words on in_valid/in_stall; the word
// with is_last set carries 0..7 tail bytes (tail_bytes) and finishes the
// message. The first word of a message loads the lanes from key_low/key_high.
// Config (key_low, key_high, variant) is written through cfg_we/cfg_index/
// cfg_wdata while the core is idle; keys are sampled at message start.
// One SipRound per cycle on a single shared round unit. A full word runs
// its update rounds (fewer for variant 1); the next word is taken in the
// cycle of the last round. A last word runs its update rounds, the final
// rounds and the emit step until the hash sits in the output register; the
// next word can follow once the core is back in idle.
// The hash is held in an output register while out_stall is high; the core
// keeps absorbing words meanwhile and only waits before emitting a new hash.
// Reset clears the message state, the output valid and restores the default
// key and variant.
// ----------------------------------------------------------------------------
module siphash_keyed_hash_core import siph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [2:0]  tail_bytes,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	logic [63:0] key_low_q, key_high_q;
	logic        variant_q;
	lanes_t      lanes_q, lanes_d, round_out, upd, fin, init_lanes, base, load;
	logic [63:0] w_q;
	logic [7:0]  len_q, base_len;
	logic        in_msg_q;
	logic        out_valid_q;
	logic [63:0] hash_q;
	logic        out_free, in_ready;
	seq_ctrl_t   ctrl;

	assign out_free = !out_valid_q || !out_stall;

	siph_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.variant  (variant_q),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	siph_round u_round (
		.lanes_in  (lanes_q),
		.lanes_out (round_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= KEY_LOW_RST;
			key_high_q <= KEY_HIGH_RST;
			variant_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_wdata;
				REG_KEY_HIGH: key_high_q <= cfg_wdata;
				REG_VARIANT:  variant_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		upd    = round_out;
		upd.v0 = round_out.v0 ^ w_q;
		fin    = upd;
		fin.v2 = upd.v2 ^ FIN_MARK;

		init_lanes.v0 = INIT0 ^ key_low_q;
		init_lanes.v1 = INIT1 ^ key_high_q;
		init_lanes.v2 = INIT2 ^ key_low_q;
		init_lanes.v3 = INIT3 ^ key_high_q;

		// a word taken in the last update round chains off the absorbed lanes
		if (!in_msg_q) begin
			base = init_lanes;
		end else if (ctrl.chain) begin
			base = upd;
		end else begin
			base = lanes_q;
		end
		base_len = in_msg_q ? len_q : 8'd0;
	end

	always_comb begin
		load    = base;
		load.v3 = base.v3 ^ (is_last ? pad_word(data_word, tail_bytes,
			base_len + {5'd0, tail_bytes}) : data_word);
		lanes_d = lanes_q;
		if (ctrl.accept) begin
			lanes_d = load;
		end else begin
			unique case (ctrl.op)
				OP_HOLD:       lanes_d = lanes_q;
				OP_ROUND:      lanes_d = round_out;
				OP_ABSORB:     lanes_d = upd;
				OP_ABSORB_FIN: lanes_d = fin;
				default:       lanes_d = lanes_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lanes_q <= lanes_d;
		if (ctrl.accept) begin
			w_q <= is_last ? load.v3 ^ base.v3 : data_word;
		end
		if (ctrl.emit) begin
			hash_q <= lanes_q.v0 ^ lanes_q.v1 ^ lanes_q.v2 ^ lanes_q.v3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= 8'd0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.accept) begin
				len_q    <= is_last ? 8'd0 : base_len + 8'd8;
				in_msg_q <= !is_last;
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall   = !in_ready;
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule
